// ===== design/afk_pkg.sv =====
// Shared types, constants and helper functions of the arm kinematics core.
// No dependencies.
package afk_pkg;

    localparam int ValueWidth  = 32;
    localparam int CordicSteps = 16;
    localparam int AngleWidth  = 17;
    localparam int RegWidth    = 16;
    localparam int OutWidth    = 32;
    localparam int ZWidth      = 31;
    localparam int XyWidth     = 33;
    localparam int NumFrames   = 5;

    localparam logic signed [17:0] FullTurn    = 18'sd46080;
    localparam logic signed [17:0] HalfTurn    = 18'sd23040;
    localparam logic signed [17:0] QuarterTurn = 18'sd11520;

    localparam logic [1:0] RegBaseHeight = 2'd0;
    localparam logic [1:0] RegUpperLink  = 2'd1;
    localparam logic [1:0] RegToolLength = 2'd2;

    localparam logic signed [XyWidth-1:0] CordicGain = 33'sd652032874;
    localparam logic signed [ValueWidth-1:0] OneQ16  = 32'sd65536;

    typedef logic signed [ValueWidth-1:0] val_t;
    typedef logic signed [OutWidth-1:0]   out_t;

    typedef struct packed {
        val_t s;
        val_t c;
    } sincos_t;

    function automatic logic signed [ZWidth-1:0] atan_lut(input logic [4:0] i);
        logic signed [ZWidth-1:0] r;
        case (i)
            5'd0:  r = 31'sd377487360;
            5'd1:  r = 31'sd222843801;
            5'd2:  r = 31'sd117744544;
            5'd3:  r = 31'sd59768969;
            5'd4:  r = 31'sd30000467;
            5'd5:  r = 31'sd15014858;
            5'd6:  r = 31'sd7509261;
            5'd7:  r = 31'sd3754860;
            5'd8:  r = 31'sd1877459;
            5'd9:  r = 31'sd938733;
            5'd10: r = 31'sd469367;
            5'd11: r = 31'sd234683;
            5'd12: r = 31'sd117342;
            5'd13: r = 31'sd58671;
            5'd14: r = 31'sd29335;
            5'd15: r = 31'sd14668;
            5'd16: r = 31'sd7334;
            5'd17: r = 31'sd3667;
            5'd18: r = 31'sd1833;
            5'd19: r = 31'sd917;
            5'd20: r = 31'sd458;
            5'd21: r = 31'sd229;
            5'd22: r = 31'sd115;
            5'd23: r = 31'sd57;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic val_t sat_v(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = (68'sd1 <<< (ValueWidth - 1)) - 68'sd1;
        lo = -hi - 68'sd1;
        if (v > hi)
            return val_t'(hi);
        else if (v < lo)
            return val_t'(lo);
        return val_t'(v);
    endfunction

    function automatic out_t sat_o(input val_t v);
        logic signed [67:0] w;
        w = 68'(v);
        if (w > 68'sd2147483647)
            return 32'sh7fffffff;
        else if (w < -68'sd2147483648)
            return 32'sh80000000;
        return out_t'(w);
    endfunction

    function automatic val_t rnd(input logic signed [67:0] p);
        return sat_v((p + 68'sd32768) >>> 16);
    endfunction

endpackage

// ===== design/afk_cordic.sv =====
// Pipelined CORDIC lane: angle in 1/128 degree to sin and cos in Q16.16.
// Depends on afk_pkg.
module afk_cordic
    import afk_pkg::*;
(
    input  logic                         clk,
    input  logic signed [AngleWidth-1:0] angle,
    output sincos_t                      result
);

    logic signed [17:0]        red;
    logic                      flip_in;
    logic signed [ZWidth-1:0]  z_reg  [0:CordicSteps];
    logic signed [XyWidth-1:0] x_reg  [0:CordicSteps];
    logic signed [XyWidth-1:0] y_reg  [0:CordicSteps];
    logic                      f_reg  [0:CordicSteps];
    logic signed [XyWidth-1:0] xr;
    logic signed [XyWidth-1:0] yr;

    always_comb
    begin
        red = 18'(angle);
        if (red >= HalfTurn)
            red = red - FullTurn;
        else if (red < -HalfTurn)
            red = red + FullTurn;
        flip_in = 1'b0;
        if (red > QuarterTurn)
        begin
            red = red - HalfTurn;
            flip_in = 1'b1;
        end
        else if (red < -QuarterTurn)
        begin
            red = red + HalfTurn;
            flip_in = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg[0] <= ZWidth'(red) <<< 16;
        x_reg[0] <= CordicGain;
        y_reg[0] <= '0;
        f_reg[0] <= flip_in;
    end

    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            f_reg[i+1] <= f_reg[i];
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_lut(5'(i));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_lut(5'(i));
            end
        end
    end

    always_comb
    begin
        xr = (x_reg[CordicSteps] + XyWidth'(8192)) >>> 14;
        yr = (y_reg[CordicSteps] + XyWidth'(8192)) >>> 14;
        result.c = f_reg[CordicSteps] ? -val_t'(xr) : val_t'(xr);
        result.s = f_reg[CordicSteps] ? -val_t'(yr) : val_t'(yr);
    end

endmodule

// ===== design/afk_chain.sv =====
// Frame chain and Jacobian column pipeline fed by the three CORDIC lanes.
// Depends on afk_pkg.
module afk_chain
    import afk_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  sincos_t       j1,
    input  sincos_t       j2,
    input  sincos_t       j3,
    input  val_t          h,
    input  val_t          link_l,
    input  val_t          link_t,
    output logic          frame_valid,
    output logic [2:0]    frame_index,
    output out_t          axis_x,
    output out_t          axis_y,
    output out_t          axis_z,
    output out_t          origin_x,
    output out_t          origin_y,
    output out_t          origin_z,
    output out_t          column_x,
    output out_t          column_y,
    output out_t          column_z,
    output logic          last
);

    // stage 1: col0/col1
    logic  v1_reg;
    val_t  c1_reg, s1_reg, c3_reg, s3_reg;
    val_t  col0_reg [0:2];
    val_t  col1_reg [0:2];
    // stage 2: o3, u
    logic  v2_reg;
    val_t  c1b_reg, s1b_reg;
    val_t  o3_reg [0:2];
    val_t  u_reg  [0:2];
    // stage 3: o4
    logic  v3_reg;
    val_t  c1c_reg, s1c_reg;
    val_t  o3c_reg [0:2];
    val_t  o4_reg  [0:2];
    // frame sequencer
    logic [4:0] busy_reg;
    logic [2:0] k_reg;
    val_t  s1q_reg, c1q_reg;
    val_t  o3q_reg [0:2];
    val_t  o4q_reg [0:2];
    val_t  h_q_reg;
    // selection of current frame
    val_t  ax [0:2];
    val_t  org [0:2];
    val_t  d [0:2];
    logic  sel_valid;
    logic [2:0] sel_k;
    // product stage
    logic  pv_reg;
    logic [2:0] pk_reg;
    val_t  pax_reg [0:2];
    val_t  porg_reg [0:2];
    logic signed [67:0] pp_reg [0:5];

    always_ff @(posedge clk)
    begin
        c1_reg <= j1.c; s1_reg <= j1.s;
        c3_reg <= j3.c; s3_reg <= j3.s;
        col0_reg[0] <= rnd(68'(j1.c) * 68'(j2.c));
        col0_reg[1] <= rnd(68'(j1.s) * 68'(j2.c));
        col0_reg[2] <= j2.s;
        col1_reg[0] <= rnd(68'(j1.c) * -68'(j2.s));
        col1_reg[1] <= rnd(68'(j1.s) * -68'(j2.s));
        col1_reg[2] <= j2.c;
    end

    always_ff @(posedge clk)
    begin
        c1b_reg <= c1_reg;
        s1b_reg <= s1_reg;
        for (int j = 0; j < 3; j++)
        begin
            u_reg[j] <= rnd(68'(col0_reg[j]) * 68'(c3_reg)
                          + 68'(col1_reg[j]) * 68'(s3_reg));
        end
        o3_reg[0] <= sat_v(68'(rnd(68'(col0_reg[0]) * 68'(link_l))));
        o3_reg[1] <= sat_v(68'(rnd(68'(col0_reg[1]) * 68'(link_l))));
        o3_reg[2] <= sat_v(68'(h) + 68'(rnd(68'(col0_reg[2]) * 68'(link_l))));
    end

    always_ff @(posedge clk)
    begin
        c1c_reg <= c1b_reg;
        s1c_reg <= s1b_reg;
        for (int j = 0; j < 3; j++)
        begin
            o3c_reg[j] <= o3_reg[j];
            o4_reg[j]  <= sat_v(68'(o3_reg[j]) + 68'(rnd(68'(u_reg[j]) * 68'(link_t))));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            busy_reg <= '0;
            k_reg    <= '0;
            pv_reg   <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            pv_reg <= sel_valid;
            if (v3_reg)
            begin
                busy_reg <= 5'b11111;
                k_reg    <= '0;
            end
            else if (busy_reg[0])
            begin
                busy_reg <= busy_reg >> 1;
                k_reg    <= k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            s1q_reg <= s1c_reg;
            c1q_reg <= c1c_reg;
            h_q_reg <= h;
            for (int j = 0; j < 3; j++)
            begin
                o3q_reg[j] <= o3c_reg[j];
                o4q_reg[j] <= o4_reg[j];
            end
        end
    end

    always_comb
    begin
        sel_valid = busy_reg[0];
        sel_k = k_reg;
        if (k_reg < 3'd2)
        begin
            ax[0] = '0; ax[1] = '0; ax[2] = OneQ16;
        end
        else
        begin
            ax[0] = s1q_reg; ax[1] = -c1q_reg; ax[2] = '0;
        end
        case (k_reg)
            3'd3:
            begin
                org[0] = o3q_reg[0]; org[1] = o3q_reg[1]; org[2] = o3q_reg[2];
            end
            3'd4:
            begin
                org[0] = o4q_reg[0]; org[1] = o4q_reg[1]; org[2] = o4q_reg[2];
            end
            default:
            begin
                org[0] = '0; org[1] = '0; org[2] = h_q_reg;
            end
        endcase
        for (int j = 0; j < 3; j++)
            d[j] = sat_v(68'(o4q_reg[j]) - 68'(org[j]));
    end

    always_ff @(posedge clk)
    begin
        pk_reg <= sel_k;
        for (int j = 0; j < 3; j++)
        begin
            pax_reg[j]  <= ax[j];
            porg_reg[j] <= org[j];
        end
        pp_reg[0] <= 68'(ax[1]) * 68'(d[2]);
        pp_reg[1] <= 68'(ax[2]) * 68'(d[1]);
        pp_reg[2] <= 68'(ax[2]) * 68'(d[0]);
        pp_reg[3] <= 68'(ax[0]) * 68'(d[2]);
        pp_reg[4] <= 68'(ax[0]) * 68'(d[1]);
        pp_reg[5] <= 68'(ax[1]) * 68'(d[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_valid <= 1'b0;
        else
            frame_valid <= pv_reg;
    end

    always_ff @(posedge clk)
    begin
        frame_index <= pk_reg;
        last        <= (pk_reg == 3'd4);
        axis_x      <= sat_o(pax_reg[0]);
        axis_y      <= sat_o(pax_reg[1]);
        axis_z      <= sat_o(pax_reg[2]);
        origin_x    <= sat_o(porg_reg[0]);
        origin_y    <= sat_o(porg_reg[1]);
        origin_z    <= sat_o(porg_reg[2]);
        column_x    <= sat_o(rnd(pp_reg[0] - pp_reg[1]));
        column_y    <= sat_o(rnd(pp_reg[2] - pp_reg[3]));
        column_z    <= sat_o(rnd(pp_reg[4] - pp_reg[5]));
    end

endmodule

// ===== design/arm_forward_kinematics_jacobian_core.sv =====
// Top level of the three-joint arm forward kinematics and Jacobian core.
// Depends on afk_pkg, afk_cordic and afk_chain.
//
// A pose is taken when start is high and busy is low; busy then stays high while
// the hold register shifts down, so a new pose waits until the frame words of the
// last one can follow on without overlap. Three CORDIC lanes (one per joint) run in
// parallel, 17 stages, followed by three chain stages, a frame hold register and
// two output stages. Five frame words leave on consecutive cycles with done high,
// frame 0 first and last on the tool frame; the receiver cannot stall them. Link
// registers are written with wr_en, wr_index and wr_data; the user must do so only
// while no pose is in flight, as the block itself does not enforce it.
module arm_forward_kinematics_jacobian_core
    import afk_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [AngleWidth-1:0] joint1_angle,
    input  logic signed [AngleWidth-1:0] joint2_angle,
    input  logic signed [AngleWidth-1:0] joint3_angle,
    input  logic                         wr_en,
    input  logic [1:0]                   wr_index,
    input  logic [RegWidth-1:0]          wr_data,
    output logic                         done,
    output logic [2:0]                   frame_index,
    output out_t                         axis_x,
    output out_t                         axis_y,
    output out_t                         axis_z,
    output out_t                         origin_x,
    output out_t                         origin_y,
    output out_t                         origin_z,
    output out_t                         column_x,
    output out_t                         column_y,
    output out_t                         column_z,
    output logic                         last
);

    logic signed [RegWidth-1:0] base_reg, upper_reg, tool_reg;
    logic [3:0] hold_reg;
    logic       accept;
    logic [CordicSteps:0] vpipe_reg;
    sincos_t    sc1, sc2, sc3;
    val_t       h, ll, tl;

    assign busy   = hold_reg != '0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= 16'sd512;
            upper_reg <= 16'sd512;
            tool_reg  <= 16'sd512;
            hold_reg  <= '0;
            vpipe_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    RegBaseHeight: base_reg  <= wr_data;
                    RegUpperLink:  upper_reg <= wr_data;
                    RegToolLength: tool_reg  <= wr_data;
                    default: ;
                endcase
            end
            hold_reg  <= accept ? 4'b1111 : (hold_reg >> 1);
            vpipe_reg <= {vpipe_reg[CordicSteps-1:0], accept};
        end
    end

    assign h  = val_t'(base_reg)  <<< 8;
    assign ll = val_t'(upper_reg) <<< 8;
    assign tl = val_t'(tool_reg)  <<< 8;

    afk_cordic u_lane1 (.clk(clk), .angle(joint1_angle), .result(sc1));
    afk_cordic u_lane2 (.clk(clk), .angle(joint2_angle), .result(sc2));
    afk_cordic u_lane3 (.clk(clk), .angle(joint3_angle), .result(sc3));

    afk_chain u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (vpipe_reg[CordicSteps]),
        .j1          (sc1),
        .j2          (sc2),
        .j3          (sc3),
        .h           (h),
        .link_l      (ll),
        .link_t      (tl),
        .frame_valid (done),
        .frame_index (frame_index),
        .axis_x      (axis_x),
        .axis_y      (axis_y),
        .axis_z      (axis_z),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .origin_z    (origin_z),
        .column_x    (column_x),
        .column_y    (column_y),
        .column_z    (column_z),
        .last        (last)
    );

endmodule

// ===== bench/tb_arm_forward_kinematics_jacobian_core.sv =====
// Self-checking bench for arm_forward_kinematics_jacobian_core: random and directed poses
// across several link-length settings, checked against an in-bench kinematics model.
// Depends on afk_pkg and the core RTL.
module tb_arm_forward_kinematics_jacobian_core;
    import afk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] RegSpare = 2'd3;
    localparam int         Settle   = 40;
    localparam longint     MaxCycles = 400000;

    localparam longint AtanDeg [24] = '{
        377487360, 222843801, 117744544, 59768969, 30000467, 15014858,
        7509261, 3754860, 1877459, 938733, 469367, 234683,
        117342, 58671, 29335, 14668, 7334, 3667,
        1833, 917, 458, 229, 115, 57
    };

    typedef struct {
        logic [AngleWidth-1:0] j1;
        logic [AngleWidth-1:0] j2;
        logic [AngleWidth-1:0] j3;
    } pose_t;

    typedef struct {
        logic [2:0]  idx;
        logic [31:0] f [9];
        logic        lst;
    } frame_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [AngleWidth-1:0] joint1_angle = '0;
    logic [AngleWidth-1:0] joint2_angle = '0;
    logic [AngleWidth-1:0] joint3_angle = '0;
    logic wr_en = 1'b0;
    logic [1:0] wr_index = '0;
    logic [RegWidth-1:0] wr_data = '0;
    logic done;
    logic [2:0] frame_index;
    out_t axis_x, axis_y, axis_z, origin_x, origin_y, origin_z;
    out_t column_x, column_y, column_z;
    logic last;

    pose_t       pose_queue [$];
    frame_word_t frame_queue [$];
    logic signed [15:0] base_h = 16'sd512;
    logic signed [15:0] upper_len = 16'sd512;
    logic signed [15:0] tool_len = 16'sd512;
    int  errors = 0;
    longint cycles = 0;
    bit  taken = 0;
    bit  burst = 0;
    int  gap = 0;

    arm_forward_kinematics_jacobian_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clampw(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic longint vsat(longint v);
        return clampw(v, ValueWidth);
    endfunction

    function automatic longint qmul(longint p);
        return vsat((p + 32768) >>> 16);
    endfunction

    task automatic joint_trig(input logic [AngleWidth-1:0] raw, output longint s,
                              output longint c);
        longint a, x, y, z, dx, dy;
        bit flip;
        a = longint'($signed(raw));
        flip = 0;
        x = 652032874;
        y = 0;
        while (a >= HalfTurn) a -= FullTurn;
        while (a < -HalfTurn) a += FullTurn;
        if (a > QuarterTurn)
        begin
            a -= HalfTurn;
            flip = 1;
        end
        else if (a < -QuarterTurn)
        begin
            a += HalfTurn;
            flip = 1;
        end
        z = a * 65536;
        for (int i = 0; i < CordicSteps && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= AtanDeg[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += AtanDeg[i];
            end
        end
        x = (x + 8192) >>> 14;
        y = (y + 8192) >>> 14;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic push_frame(int k, longint ax [3], longint org [3], longint tip [3]);
        frame_word_t w;
        longint d [3];
        for (int j = 0; j < 3; j++)
            d[j] = vsat(tip[j] - org[j]);
        w.idx = k[2:0];
        for (int j = 0; j < 3; j++)
        begin
            w.f[j] = 32'(clampw(ax[j], 32));
            w.f[3 + j] = 32'(clampw(org[j], 32));
        end
        w.f[6] = 32'(clampw(qmul(ax[1] * d[2] - ax[2] * d[1]), 32));
        w.f[7] = 32'(clampw(qmul(ax[2] * d[0] - ax[0] * d[2]), 32));
        w.f[8] = 32'(clampw(qmul(ax[0] * d[1] - ax[1] * d[0]), 32));
        w.lst = (k == NumFrames - 1);
        frame_queue.push_back(w);
    endtask

    task automatic predict_pose(pose_t p);
        longint s1, c1, s2, c2, s3, c3, h, ul, tl;
        longint zup [3], ztilt [3], col0 [3], col1 [3], u [3], o0 [3], o3 [3], o4 [3];
        h = vsat(longint'(base_h) * 256);
        ul = vsat(longint'(upper_len) * 256);
        tl = vsat(longint'(tool_len) * 256);
        joint_trig(p.j1, s1, c1);
        joint_trig(p.j2, s2, c2);
        joint_trig(p.j3, s3, c3);
        zup = '{0, 0, 65536};
        ztilt = '{s1, -c1, 0};
        o0 = '{0, 0, h};
        col0 = '{qmul(c1 * c2), qmul(s1 * c2), s2};
        col1 = '{qmul(-c1 * s2), qmul(-s1 * s2), c2};
        for (int j = 0; j < 3; j++)
        begin
            o3[j] = vsat(o0[j] + qmul(col0[j] * ul));
            u[j] = qmul(col0[j] * c3 + col1[j] * s3);
        end
        for (int j = 0; j < 3; j++)
            o4[j] = vsat(o3[j] + qmul(u[j] * tl));
        push_frame(0, zup, o0, o4);
        push_frame(1, zup, o0, o4);
        push_frame(2, ztilt, o0, o4);
        push_frame(3, ztilt, o3, o4);
        push_frame(4, ztilt, o4, o4);
    endtask

    // accept poses and check frame words
    always @(posedge clk)
    begin
        frame_word_t w;
        out_t got [9];
        cycles++;
        taken = start && !busy;
        if (taken)
            predict_pose('{joint1_angle, joint2_angle, joint3_angle});
        if (done)
        begin
            if (frame_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, got frame %0d", $time, frame_index);
            end
            else
            begin
                w = frame_queue.pop_front();
                got = '{axis_x, axis_y, axis_z, origin_x, origin_y, origin_z,
                        column_x, column_y, column_z};
                if (frame_index !== w.idx || last !== w.lst)
                begin
                    errors++;
                    $display("%0t: frame/last exp %0d/%0b got %0d/%0b", $time,
                             w.idx, w.lst, frame_index, last);
                end
                for (int j = 0; j < 9; j++)
                    if (got[j] !== w.f[j])
                    begin
                        errors++;
                        $display("%0t: frame %0d field %0d exp %0d got %0d", $time,
                                 w.idx, j, $signed(w.f[j]), got[j]);
                    end
            end
        end
        if (cycles > MaxCycles)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // pose driver
    always @(negedge clk)
    begin
        pose_t p;
        if (!(start && !taken))
        begin
            if (gap > 0)
            begin
                gap--;
                start <= 1'b0;
            end
            else if (pose_queue.size() > 0)
            begin
                p = pose_queue.pop_front();
                joint1_angle <= p.j1;
                joint2_angle <= p.j2;
                joint3_angle <= p.j3;
                start <= 1'b1;
                gap = burst ? 0 : $urandom_range(0, 13);
            end
            else
                start <= 1'b0;
        end
    end

    function automatic logic [AngleWidth-1:0] rand_angle();
        int q;
        case ($urandom_range(0, 5))
            0: return AngleWidth'($urandom());
            1: return AngleWidth'($urandom_range(0, 2 * 46080) - 46080);
            2:
            begin
                q = $urandom_range(0, 8) - 4;
                return AngleWidth'(q * 11520 + $urandom_range(0, 4) - 2);
            end
            3: return AngleWidth'($urandom_range(0, 256) - 128);
            default: return AngleWidth'($urandom_range(0, 2 * 23040) - 23040);
        endcase
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            RegBaseHeight: base_h = val;
            RegUpperLink:  upper_len = val;
            RegToolLength: tool_len = val;
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic drain();
        wait (pose_queue.size() == 0 && !start && frame_queue.size() == 0);
        repeat (Settle) @(negedge clk);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 20 == 0)
                burst = ($urandom_range(0, 3) == 0);
            pose_queue.push_back('{rand_angle(), rand_angle(), rand_angle()});
        end
        drain();
    endtask

    initial
    begin
        logic [AngleWidth-1:0] edges [12];
        edges = '{17'd0, 17'd46080, -17'sd46080, 17'h0ffff, 17'h10000, 17'd11520,
                  -17'sd11520, 17'd11521, -17'sd11521, 17'd23040, -17'sd23040, 17'd23039};
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);
        for (int i = 0; i < 12; i++)
            pose_queue.push_back('{edges[i], edges[(i + 4) % 12], edges[(i + 7) % 12]});
        pose_queue.push_back('{17'h1ffff, 17'h1ffff, 17'h1ffff});
        drain();
        random_phase(60);

        write_reg(RegBaseHeight, 16'h7fff);
        write_reg(RegUpperLink, 16'h7fff);
        write_reg(RegToolLength, 16'h7fff);
        write_reg(RegSpare, 16'h1234);
        for (int i = 0; i < 6; i++)
            pose_queue.push_back('{edges[i], edges[i + 6], edges[11 - i]});
        random_phase(60);

        write_reg(RegBaseHeight, 16'h8000);
        write_reg(RegUpperLink, 16'h8000);
        write_reg(RegToolLength, 16'h8000);
        random_phase(60);

        write_reg(RegBaseHeight, 16'h0000);
        write_reg(RegUpperLink, 16'h7fff);
        write_reg(RegToolLength, 16'h8000);
        random_phase(60);

        write_reg(RegBaseHeight, 16'hffff);
        write_reg(RegUpperLink, 16'h0000);
        write_reg(RegToolLength, 16'h0001);
        random_phase(50);

        for (int k = 0; k < 3; k++)
        begin
            write_reg(RegBaseHeight, 16'($urandom()));
            write_reg(RegUpperLink, 16'($urandom()));
            write_reg(RegToolLength, 16'($urandom()));
            random_phase(40);
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== arm_forward_kinematics_jacobian_core.f =====
design/afk_pkg.sv
design/afk_cordic.sv
design/afk_chain.sv
design/arm_forward_kinematics_jacobian_core.sv
bench/tb_arm_forward_kinematics_jacobian_core.sv
